/* hw/rtl/expiring_queue_batch_dispatch_macros.svh */
// assertion macros shared by the expiring queue rtl
// depends on a clock named clock and a reset named reset in the using module
`ifndef EXPIRING_QUEUE_BATCH_DISPATCH_MACROS_SVH
`define EXPIRING_QUEUE_BATCH_DISPATCH_MACROS_SVH

// condition holds at every edge outside reset
`define EQBD_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define EQBD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/eqbd_pkg.sv */
// package for the expiring queue: sizes, word types, codes and controller links
// no dependencies
package eqbd_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int MAX_SEATS   = 16;

   // derived widths
   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int SEAT_W  = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;
   localparam int SCNT_W  = $clog2(MAX_SEATS + 1);
   localparam int IDX_W   = (CNT_W > SCNT_W) ? CNT_W : SCNT_W;
   localparam int REQN_W  = 5;
   localparam int MIN_W   = (IDX_W > REQN_W) ? IDX_W : REQN_W;

   localparam logic [REQN_W-1:0] SEAT_LIMIT_RESET = 5'd8;

   typedef enum logic [1:0] {
      CMD_ARRIVE = 2'd0,
      CMD_START  = 2'd1,
      CMD_END    = 2'd2,
      CMD_TICK   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_LENGTH = 2'd0,
      KIND_SEAT   = 2'd1,
      KIND_DONE   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] entry_id;
      logic [15:0] patience;
      logic [4:0]  requested;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] out_id;
      logic [6:0]  count;
      logic        rejected;
      logic [31:0] dropped_total;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] patience;
   } wait_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ARRIVE,
      ST_START_RD,
      ST_START_WR,
      ST_END_RD,
      ST_END_EMIT,
      ST_END_DONE,
      ST_TICK_RD,
      ST_TICK_WR,
      ST_TICK_FIN
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic loop_init;
      logic arrive;
      logic start_rd;
      logic start_wr;
      logic start_fin;
      logic end_rd;
      logic end_emit;
      logic end_done;
      logic tick_rd;
      logic tick_wr;
      logic tick_fin;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      cmd_type cmd;
      logic    loop_done;
      logic    any_removed;
      logic    out_free;
   } dp_status_type;

   // circular pointer step
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

/* hw/rtl/eqbd_ctrl.sv */
// controller state machine for the expiring queue
// depends on eqbd_pkg
module eqbd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  eqbd_pkg::dp_status_type status,
   output eqbd_pkg::ctl_cmd_type   cmd
);

   eqbd_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= eqbd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         eqbd_pkg::ST_IDLE: begin
            if (req_valid) state_in = eqbd_pkg::ST_DECODE;
         end
         eqbd_pkg::ST_DECODE: begin
            case (status.cmd)
               eqbd_pkg::CMD_ARRIVE: state_in = eqbd_pkg::ST_ARRIVE;
               eqbd_pkg::CMD_START:  state_in = eqbd_pkg::ST_START_RD;
               eqbd_pkg::CMD_END:    state_in = eqbd_pkg::ST_END_RD;
               default:              state_in = eqbd_pkg::ST_TICK_RD;
            endcase
         end
         eqbd_pkg::ST_ARRIVE: begin
            if (status.out_free) state_in = eqbd_pkg::ST_IDLE;
         end
         eqbd_pkg::ST_START_RD: begin
            state_in = status.loop_done ? eqbd_pkg::ST_IDLE : eqbd_pkg::ST_START_WR;
         end
         eqbd_pkg::ST_START_WR: state_in = eqbd_pkg::ST_START_RD;
         eqbd_pkg::ST_END_RD: begin
            state_in = status.loop_done ? eqbd_pkg::ST_END_DONE : eqbd_pkg::ST_END_EMIT;
         end
         eqbd_pkg::ST_END_EMIT: begin
            if (status.out_free) state_in = eqbd_pkg::ST_END_RD;
         end
         eqbd_pkg::ST_END_DONE: begin
            if (status.out_free) state_in = eqbd_pkg::ST_IDLE;
         end
         eqbd_pkg::ST_TICK_RD: begin
            state_in = status.loop_done ? eqbd_pkg::ST_TICK_FIN : eqbd_pkg::ST_TICK_WR;
         end
         eqbd_pkg::ST_TICK_WR: state_in = eqbd_pkg::ST_TICK_RD;
         eqbd_pkg::ST_TICK_FIN: begin
            if (!status.any_removed || status.out_free) state_in = eqbd_pkg::ST_IDLE;
         end
         default: state_in = eqbd_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         eqbd_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         eqbd_pkg::ST_DECODE:   cmd.loop_init = 1'b1;
         eqbd_pkg::ST_ARRIVE:   cmd.arrive    = status.out_free;
         eqbd_pkg::ST_START_RD: begin
            cmd.start_fin = status.loop_done;
            cmd.start_rd  = !status.loop_done;
         end
         eqbd_pkg::ST_START_WR: cmd.start_wr  = 1'b1;
         eqbd_pkg::ST_END_RD:   cmd.end_rd    = !status.loop_done;
         eqbd_pkg::ST_END_EMIT: cmd.end_emit  = status.out_free;
         eqbd_pkg::ST_END_DONE: cmd.end_done  = status.out_free;
         eqbd_pkg::ST_TICK_RD:  cmd.tick_rd   = !status.loop_done;
         eqbd_pkg::ST_TICK_WR:  cmd.tick_wr   = 1'b1;
         eqbd_pkg::ST_TICK_FIN: begin
            cmd.tick_fin = !status.any_removed || status.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

/* hw/rtl/eqbd_datapath.sv */
// datapath for the expiring queue: waiting store, seat store, counters, result register
// depends on eqbd_pkg and the macros header
`include "expiring_queue_batch_dispatch_macros.svh"

module eqbd_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  eqbd_pkg::req_word_type  req_word,
   input  logic                    csr_write_en,
   input  logic [4:0]              csr_write_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output eqbd_pkg::rsp_word_type  rsp_word,
   input  eqbd_pkg::ctl_cmd_type   cmd,
   output eqbd_pkg::dp_status_type status
);

   localparam int PW = eqbd_pkg::PTR_W;
   localparam int CW = eqbd_pkg::CNT_W;
   localparam int SW = eqbd_pkg::SEAT_W;
   localparam int UW = eqbd_pkg::SCNT_W;
   localparam int XW = eqbd_pkg::IDX_W;
   localparam int MW = eqbd_pkg::MIN_W;

   // stores
   eqbd_pkg::wait_entry_type wait_mem [eqbd_pkg::QUEUE_DEPTH];
   logic [15:0]              seat_mem [eqbd_pkg::MAX_SEATS];

   eqbd_pkg::req_word_type   item_ff, item_in;
   logic [4:0]               limit_ff, limit_in;
   logic [PW-1:0]            head_ff, head_in, tail_ff, tail_in;
   logic [PW-1:0]            rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]            count_ff, count_in, removed_ff, removed_in;
   logic [UW-1:0]            used_ff, used_in, n_ff, n_in;
   logic [XW-1:0]            idx_ff, idx_in;
   logic [31:0]              drop_ff, drop_in;
   eqbd_pkg::wait_entry_type wait_rd_ff;
   logic [15:0]              seat_rd_ff;
   eqbd_pkg::rsp_word_type   rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic                     full;
   logic                     out_free;
   logic [4:0]               lim_a;
   logic [UW-1:0]            free_seats;
   logic [MW-1:0]            m1, m2;
   logic [XW-1:0]            loop_limit;
   logic [XW:0]              seat_wsum;
   logic [CW-1:0]            drop_amt;
   logic [32:0]              drop_sum;
   logic [31:0]              drop_sat;
   logic [CW-1:0]            keep_count;
   logic                     wait_we;
   logic [PW-1:0]            wait_waddr;
   eqbd_pkg::wait_entry_type wait_wdata;

   assign full       = (count_ff == CW'(eqbd_pkg::QUEUE_DEPTH));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign keep_count = count_ff - removed_ff;

   // seats taken by a start
   assign lim_a      = (item_ff.requested < limit_ff) ? item_ff.requested : limit_ff;
   assign free_seats = UW'(eqbd_pkg::MAX_SEATS) - used_ff;
   assign m1 = (MW'(lim_a) < MW'(free_seats)) ? MW'(lim_a) : MW'(free_seats);
   assign m2 = (m1 < MW'(count_ff)) ? m1 : MW'(count_ff);

   // loop bound per command
   always_comb begin
      case (eqbd_pkg::cmd_type'(item_ff.cmd))
         eqbd_pkg::CMD_START: loop_limit = XW'(n_ff);
         eqbd_pkg::CMD_END:   loop_limit = XW'(used_ff);
         default:             loop_limit = XW'(count_ff);
      endcase
   end

   assign seat_wsum = {1'b0, XW'(used_ff)} + {1'b0, idx_ff};

   // saturating drop counter
   assign drop_amt = cmd.tick_fin ? removed_ff : CW'(1);
   assign drop_sum = {1'b0, drop_ff} + 33'(drop_amt);
   assign drop_sat = drop_sum[32] ? 32'hFFFF_FFFF : drop_sum[31:0];

   assign status.cmd         = eqbd_pkg::cmd_type'(item_ff.cmd);
   assign status.loop_done   = (idx_ff == loop_limit);
   assign status.any_removed = (removed_ff != '0);
   assign status.out_free    = out_free;

   // waiting store write port
   always_comb begin
      wait_we    = 1'b0;
      wait_waddr = tail_ff;
      wait_wdata = '{id: item_ff.entry_id, patience: item_ff.patience};
      if (cmd.arrive && !full) begin
         wait_we = 1'b1;
      end else if (cmd.tick_wr && wait_rd_ff.patience > 16'd1) begin
         wait_we    = 1'b1;
         wait_waddr = wr_ptr_ff;
         wait_wdata = '{id: wait_rd_ff.id, patience: wait_rd_ff.patience - 16'd1};
      end
   end

   always_ff @(posedge clock) begin
      if (wait_we) wait_mem[wait_waddr] <= wait_wdata;
      if (cmd.start_rd || cmd.tick_rd) wait_rd_ff <= wait_mem[rd_ptr_ff];
   end

   // seat store
   always_ff @(posedge clock) begin
      if (cmd.start_wr) seat_mem[seat_wsum[SW-1:0]] <= wait_rd_ff.id;
      if (cmd.end_rd) seat_rd_ff <= seat_mem[idx_ff[SW-1:0]];
   end

   // control and counter next values
   always_comb begin
      item_in      = item_ff;
      limit_in     = limit_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      count_in     = count_ff;
      removed_in   = removed_ff;
      used_in      = used_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      drop_in      = drop_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_write_en) limit_in = csr_write_data;
      if (cmd.capture)  item_in  = req_word;

      if (cmd.loop_init) begin
         idx_in     = '0;
         rd_ptr_in  = head_ff;
         wr_ptr_in  = head_ff;
         removed_in = '0;
         n_in       = UW'(m2);
      end

      if (cmd.arrive) begin
         rsp_in       = '0;
         rsp_in.kind  = eqbd_pkg::KIND_LENGTH;
         rsp_in.last  = 1'b1;
         rsp_valid_in = 1'b1;
         if (full) begin
            drop_in              = drop_sat;
            rsp_in.count         = 7'(count_ff);
            rsp_in.rejected      = 1'b1;
            rsp_in.dropped_total = drop_sat;
         end else begin
            tail_in              = eqbd_pkg::ptr_next(tail_ff);
            count_in             = count_ff + 1'b1;
            rsp_in.count         = 7'(count_ff + 1'b1);
            rsp_in.dropped_total = drop_ff;
         end
      end

      // start: move head entries to seats
      if (cmd.start_rd) rd_ptr_in = eqbd_pkg::ptr_next(rd_ptr_ff);
      if (cmd.start_wr) idx_in    = idx_ff + 1'b1;
      if (cmd.start_fin) begin
         head_in  = rd_ptr_ff;
         count_in = count_ff - CW'(n_ff);
         used_in  = used_ff + n_ff;
      end

      // end: drain seats in order
      if (cmd.end_emit) begin
         idx_in               = idx_ff + 1'b1;
         rsp_in               = '0;
         rsp_in.kind          = eqbd_pkg::KIND_SEAT;
         rsp_in.out_id        = seat_rd_ff;
         rsp_in.dropped_total = drop_ff;
         rsp_valid_in         = 1'b1;
      end
      if (cmd.end_done) begin
         used_in              = '0;
         rsp_in               = '0;
         rsp_in.kind          = eqbd_pkg::KIND_DONE;
         rsp_in.count         = 7'(used_ff);
         rsp_in.dropped_total = drop_ff;
         rsp_in.last          = 1'b1;
         rsp_valid_in         = 1'b1;
      end

      // tick: age and compact
      if (cmd.tick_rd) begin
         rd_ptr_in = eqbd_pkg::ptr_next(rd_ptr_ff);
         idx_in    = idx_ff + 1'b1;
      end
      if (cmd.tick_wr) begin
         if (wait_rd_ff.patience > 16'd1) begin
            wr_ptr_in = eqbd_pkg::ptr_next(wr_ptr_ff);
         end else begin
            removed_in = removed_ff + 1'b1;
         end
      end
      if (cmd.tick_fin) begin
         tail_in  = wr_ptr_ff;
         count_in = keep_count;
         if (removed_ff != '0) begin
            drop_in              = drop_sat;
            rsp_in               = '0;
            rsp_in.kind          = eqbd_pkg::KIND_LENGTH;
            rsp_in.count         = 7'(keep_count);
            rsp_in.dropped_total = drop_sat;
            rsp_in.last          = 1'b1;
            rsp_valid_in         = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= eqbd_pkg::SEAT_LIMIT_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         used_ff      <= '0;
         drop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      rd_ptr_ff  <= rd_ptr_in;
      wr_ptr_ff  <= wr_ptr_in;
      removed_ff <= removed_in;
      n_ff       <= n_in;
      idx_ff     <= idx_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `EQBD_ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(eqbd_pkg::QUEUE_DEPTH), "queue over depth")
   `EQBD_ASSERT_ALWAYS(a_seat_bound, used_ff <= UW'(eqbd_pkg::MAX_SEATS), "seats over limit")
   `EQBD_ASSERT_NEXT(a_drop_mono, 1'b1, drop_ff >= $past(drop_ff), "drop count went down")
   `EQBD_ASSERT_NEXT(a_tick_keep, cmd.tick_wr, removed_ff <= count_ff, "removed past length")

endmodule

/* hw/rtl/expiring_queue_batch_dispatch.sv */
// top level of the expiring queue with batch seating
// depends on eqbd_pkg, eqbd_ctrl and eqbd_datapath
//
// Waiting queue of (id, patience) words with batched seating and patience
// expiry. One word is handled at a time: req_stall is low only while idle.
// The waiting store is a single-port circular memory stepped one entry at
// a time, a read state followed by a write state per entry; start and tick
// walk it this way, and end walks the seat store with a read state and an
// emit state per seat, also waiting on any output stall. The result
// register lets the next result be loaded in the cycle the current one is
// taken.
module expiring_queue_batch_dispatch (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  eqbd_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output eqbd_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write_en,
   input  logic [4:0]             csr_write_data
);

   eqbd_pkg::ctl_cmd_type   cmd;
   eqbd_pkg::dp_status_type status;

   // sequencing
   eqbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // stores and counters
   eqbd_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_word       (req_word),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

/* dv/tb.sv */
// testbench for expiring_queue_batch_dispatch: directed and random words on the request side
// depends on eqbd_pkg and the expiring_queue_batch_dispatch rtl
`timescale 1ns / 1ps

module tb;

   localparam int WATCHDOG_LIMIT = 20000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   eqbd_pkg::req_word_type req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   eqbd_pkg::rsp_word_type rsp_word;
   logic                   csr_write_en = 1'b0;
   logic [4:0]             csr_write_data = '0;

   expiring_queue_batch_dispatch u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data)
   );

   always #2 clock = ~clock;

   // shadow state of the queue and seats
   logic [15:0]            line_ids[$];
   logic [15:0]            line_pat[$];
   logic [15:0]            seated[$];
   logic [31:0]            drops;
   logic [4:0]             seat_cap;
   eqbd_pkg::rsp_word_type pending_rsp[$];
   int                     errors = 0;
   int                     idle_cycles = 0;
   bit                     calm = 1'b0;
   bit                     rsp_noise = 1'b0;

   function automatic eqbd_pkg::rsp_word_type make_rsp(logic [1:0] k, logic [15:0] id,
                                                       logic [6:0] c, logic r, logic l);
      eqbd_pkg::rsp_word_type w;
      w.kind = k; w.out_id = id; w.count = c; w.rejected = r;
      w.dropped_total = drops; w.last = l;
      return w;
   endfunction

   function automatic void add_drops(int n);
      if (64'(drops) + n > 64'hFFFF_FFFF) drops = 32'hFFFF_FFFF;
      else drops = drops + n;
   endfunction

   // expected results for one accepted word
   function automatic void predict_queue(eqbd_pkg::req_word_type w);
      int n, gone;
      logic [15:0] ki[$], kp[$];
      case (eqbd_pkg::cmd_type'(w.cmd))
         eqbd_pkg::CMD_ARRIVE: begin
            if (line_ids.size() >= eqbd_pkg::QUEUE_DEPTH) begin
               add_drops(1);
               pending_rsp.push_back(make_rsp(eqbd_pkg::KIND_LENGTH, 0,
                                              7'(line_ids.size()), 1, 1));
            end else begin
               line_ids.push_back(w.entry_id);
               line_pat.push_back(w.patience);
               pending_rsp.push_back(make_rsp(eqbd_pkg::KIND_LENGTH, 0,
                                              7'(line_ids.size()), 0, 1));
            end
         end
         eqbd_pkg::CMD_START: begin
            n = w.requested;
            if (n > seat_cap) n = seat_cap;
            if (n > eqbd_pkg::MAX_SEATS - seated.size())
               n = eqbd_pkg::MAX_SEATS - seated.size();
            if (n > line_ids.size()) n = line_ids.size();
            repeat (n) begin
               seated.push_back(line_ids.pop_front());
               void'(line_pat.pop_front());
            end
         end
         eqbd_pkg::CMD_END: begin
            foreach (seated[i])
               pending_rsp.push_back(make_rsp(eqbd_pkg::KIND_SEAT, seated[i], 0, 0, 0));
            pending_rsp.push_back(make_rsp(eqbd_pkg::KIND_DONE, 0, 7'(seated.size()), 0, 1));
            seated.delete();
         end
         default: begin
            gone = 0;
            foreach (line_ids[i]) begin
               if (line_pat[i] <= 1) gone++;
               else begin
                  ki.push_back(line_ids[i]);
                  kp.push_back(line_pat[i] - 16'd1);
               end
            end
            line_ids = ki;
            line_pat = kp;
            if (gone > 0) begin
               add_drops(gone);
               pending_rsp.push_back(make_rsp(eqbd_pkg::KIND_LENGTH, 0,
                                              7'(line_ids.size()), 0, 1));
            end
         end
      endcase
   endfunction

   // result checker and receiver stalls
   always @(posedge clock) begin
      eqbd_pkg::rsp_word_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               $error("unexpected result word %h", rsp_word);
               errors++;
            end else begin
               e = pending_rsp.pop_front();
               if (rsp_word.kind != e.kind) begin
                  $error("kind exp %0d got %0d", e.kind, rsp_word.kind); errors++;
               end
               if (rsp_word.out_id != e.out_id) begin
                  $error("out_id exp %0d got %0d", e.out_id, rsp_word.out_id); errors++;
               end
               if (rsp_word.count != e.count) begin
                  $error("count exp %0d got %0d", e.count, rsp_word.count); errors++;
               end
               if (rsp_word.rejected != e.rejected) begin
                  $error("rejected exp %0d got %0d", e.rejected, rsp_word.rejected); errors++;
               end
               if (rsp_word.dropped_total != e.dropped_total) begin
                  $error("dropped_total exp %0d got %0d", e.dropped_total,
                         rsp_word.dropped_total);
                  errors++;
               end
               if (rsp_word.last != e.last) begin
                  $error("last exp %0d got %0d", e.last, rsp_word.last); errors++;
               end
            end
         end
         if (!calm && rsp_noise) rsp_stall <= ($urandom_range(0, 3) == 0);
         else rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || pending_rsp.size() == 0 && !req_valid)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // send one word, with a random gap in front
   task automatic send_word(eqbd_pkg::req_word_type w);
      if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) @(posedge clock);
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_queue(w);
      req_valid <= 1'b0;
      // block is busy for the next cycle anyway
      @(posedge clock);
   endtask

   task automatic send_cmd(eqbd_pkg::cmd_type c, logic [15:0] id, logic [15:0] p,
                           logic [4:0] r);
      eqbd_pkg::req_word_type w;
      w.cmd = c; w.entry_id = id; w.patience = p; w.requested = r;
      send_word(w);
   endtask

   // wait until idle, then write the seat limit
   task automatic set_seat_limit(logic [4:0] v);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (140) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      seat_cap = v;
   endtask

   task automatic test_directed();
      send_cmd(eqbd_pkg::CMD_END, 16'hFFFF, 16'hFFFF, 5'd31);
      send_cmd(eqbd_pkg::CMD_TICK, 16'h0, 16'h0, 5'd0);
      send_cmd(eqbd_pkg::CMD_ARRIVE, 16'h0000, 16'd1, 5'd0);
      send_cmd(eqbd_pkg::CMD_ARRIVE, 16'hFFFF, 16'hFFFF, 5'd31);
      send_cmd(eqbd_pkg::CMD_ARRIVE, 16'h5A5A, 16'd2, 5'd0);
      send_cmd(eqbd_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF, 5'd31);
      send_cmd(eqbd_pkg::CMD_START, 16'h0, 16'h0, 5'd0);
      send_cmd(eqbd_pkg::CMD_START, 16'h0, 16'h0, 5'd16);
      send_cmd(eqbd_pkg::CMD_END, 16'h0, 16'h0, 5'd0);
      send_cmd(eqbd_pkg::CMD_TICK, 16'h0, 16'h0, 5'd0);
   endtask

   // fill past full to reach rejections, then seat in batches
   task automatic test_full_queue();
      repeat (eqbd_pkg::QUEUE_DEPTH + 3)
         send_cmd(eqbd_pkg::CMD_ARRIVE, 16'($urandom), 16'($urandom_range(2, 6)),
                  5'($urandom));
      set_seat_limit(5'd16);
      send_cmd(eqbd_pkg::CMD_START, 16'h0, 16'h0, 5'd16);
      send_cmd(eqbd_pkg::CMD_START, 16'h0, 16'h0, 5'd4);
      send_cmd(eqbd_pkg::CMD_END, 16'h0, 16'h0, 5'd0);
      send_cmd(eqbd_pkg::CMD_START, 16'h0, 16'h0, 5'd31);
      send_cmd(eqbd_pkg::CMD_END, 16'h0, 16'h0, 5'd0);
      repeat (6) send_cmd(eqbd_pkg::CMD_TICK, 16'h0, 16'h0, 5'd0);
   endtask

   task automatic test_random(int items);
      eqbd_pkg::req_word_type w;
      repeat (items) begin
         w = eqbd_pkg::req_word_type'($urandom);
         w.entry_id = 16'($urandom);
         w.patience = ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                                                    16'($urandom_range(1, 5));
         case ($urandom_range(0, 9))
            0, 1, 2, 3: w.cmd = eqbd_pkg::CMD_ARRIVE;
            4, 5:       w.cmd = eqbd_pkg::CMD_START;
            6:          w.cmd = eqbd_pkg::CMD_END;
            default:    w.cmd = eqbd_pkg::CMD_TICK;
         endcase
         send_word(w);
      end
   endtask

   initial begin
      seat_cap = eqbd_pkg::SEAT_LIMIT_RESET;
      drops = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      rsp_noise = 1'b1;
      test_directed();
      test_full_queue();
      set_seat_limit(5'd1);
      test_random(24);
      set_seat_limit(5'd0);
      test_random(10);
      set_seat_limit(5'd5);
      test_random(24);
      calm = 1'b1;
      test_random(15);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (errors == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end
endmodule
